// ----- hdl/sjfs_pkg.sv -----
// Shared types, constants and codes for the shortest-job-first scheduler.
package sjfs_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int DATA_W    = 16;
    localparam int TIME_W    = 21;
    localparam int OUT_IDX_W = 4;

    typedef logic [DATA_W-1:0]    data_t;
    typedef logic [TIME_W-1:0]    time_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [OUT_IDX_W-1:0] out_idx_t;

    typedef struct packed {
        data_t arrival;
        data_t burst;
    } entry_t;

    // Write port of the process store.
    typedef struct packed {
        logic   we;
        idx_t   addr;
        entry_t data;
    } mem_wr_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_CT,
        ST_TAT,
        ST_WT
    } state_t;

endpackage

// ----- hdl/sjfs_if.sv -----
// Valid/ready channel interfaces for process beats and result beats.
interface sjfs_job_if
    import sjfs_pkg::*;
();
    logic  valid;
    logic  ready;
    data_t arrival_time;
    data_t burst_time;
    logic  is_last;

    modport source (output valid, output arrival_time, output burst_time, output is_last,
                    input ready);
    modport sink   (input valid, input arrival_time, input burst_time, input is_last,
                    output ready);
endinterface

interface sjfs_result_if
    import sjfs_pkg::*;
();
    logic     valid;
    logic     ready;
    out_idx_t served_index;
    data_t    served_arrival;
    data_t    served_burst;
    time_t    completion_time;
    time_t    turnaround_time;
    time_t    waiting_time;
    logic     final_entry;

    modport source (output valid, output served_index, output served_arrival,
                    output served_burst, output completion_time, output turnaround_time,
                    output waiting_time, output final_entry, input ready);
    modport sink   (input valid, input served_index, input served_arrival,
                    input served_burst, input completion_time, input turnaround_time,
                    input waiting_time, input final_entry, output ready);
endinterface

// ----- hdl/sjfs_mem.sv -----
// Process store: one write port, one registered read port.
module sjfs_mem
    import sjfs_pkg::*;
(
    input  logic    clk,
    input  mem_wr_t wr,
    input  idx_t    rd_addr,
    output entry_t  rd_data
);

    entry_t mem [MAX_PROCS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/sjfs_alu.sv -----
// Shared add/subtract unit used for completion, turnaround and waiting times.
module sjfs_alu
    import sjfs_pkg::*;
(
    input  alu_op_t op,
    input  time_t   a,
    input  time_t   b,
    output time_t   y
);

    always_comb
    begin
        unique case (op)
            ALU_ADD: y = a + b;
            ALU_SUB: y = a - b;
            default: y = a + b;
        endcase
    end

endmodule

// ----- hdl/sjfs_top.sv -----
// Top level of the non-preemptive shortest-job-first scheduler.
//
// Processes are loaded one beat per cycle on job (arrival and burst, 16 bits
// each, up to MAX_PROCS = 16 of them; extra beats are dropped but is_last
// still counts). The beat with is_last set is stored and then starts a run:
// from time zero the block repeatedly serves, among pending processes that
// have arrived, the one with the shortest burst (lowest load index on a
// tie); when none has arrived, time jumps to the earliest pending arrival.
// One result beat per process comes out in service order, the last flagged
// by final_entry. job.ready is low for the whole run. Each served process
// costs a scan of the n stored entries through the single read port of the
// store, a drain and a decide state, then three passes through the shared
// add/subtract unit; a time jump forces a second scan. The next scan starts
// while a result still sits in the output register; the block waits only
// if that register is still full when the following result is ready. Store
// contents need no clearing.
module sjfs_top
    import sjfs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sjfs_job_if.sink      job,
    sjfs_result_if.source result
);

    state_t state_reg, state_next;

    cnt_t  loaded_reg, scan_reg, served_reg;
    logic [MAX_PROCS-1:0] done_reg;
    time_t time_reg, ct_reg, tat_reg;

    // scan results
    logic  eval_vld_reg;
    idx_t  eval_idx_reg;
    logic  found_reg;
    idx_t  best_idx_reg;
    data_t best_arr_reg, best_bur_reg, early_reg;

    // output register
    logic     out_vld_reg;
    out_idx_t out_idx_reg;
    data_t    out_arr_reg, out_bur_reg;
    time_t    out_ct_reg, out_tat_reg, out_wt_reg;
    logic     out_last_reg;

    mem_wr_t mem_wr;
    idx_t    rd_addr;
    entry_t  rd_entry;
    alu_op_t alu_op;
    time_t   alu_a, alu_b, alu_y;

    logic job_acc, full, last_scan, run_done, out_free, scan_start, commit;
    logic eval_pend, eval_arrived, eval_take;

    sjfs_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    sjfs_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    assign job_acc   = job.valid && job.ready;
    assign full      = (loaded_reg == CNT_W'(MAX_PROCS));
    assign last_scan = (scan_reg == loaded_reg - cnt_t'(1));
    assign run_done  = ((served_reg + cnt_t'(1)) == loaded_reg);
    assign out_free  = !out_vld_reg || result.ready;
    assign commit    = (state_reg == ST_WT) && out_free;

    // candidate test on the entry coming back from the store
    assign eval_pend    = !done_reg[eval_idx_reg];
    assign eval_arrived = (TIME_W'(rd_entry.arrival) <= time_reg);
    assign eval_take    = eval_pend && eval_arrived &&
                          (!found_reg || (rd_entry.burst < best_bur_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (job_acc && job.is_last)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_scan)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = found_reg ? ST_CT : ST_SCAN;
            ST_CT:     state_next = ST_TAT;
            ST_TAT:    state_next = ST_WT;
            ST_WT:
            begin
                if (out_free)
                begin
                    state_next = run_done ? ST_LOAD : ST_SCAN;
                end
            end
            default:   state_next = ST_LOAD;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        job.ready          = rst_n && (state_reg == ST_LOAD);
        mem_wr.we          = job_acc && !full;
        mem_wr.addr        = loaded_reg[IDX_W-1:0];
        mem_wr.data        = '{arrival: job.arrival_time, burst: job.burst_time};
        rd_addr            = scan_reg[IDX_W-1:0];
        alu_op             = ALU_ADD;
        alu_a              = time_reg;
        alu_b              = TIME_W'(best_bur_reg);
        scan_start         = 1'b0;
        unique case (state_reg)
            ST_LOAD:   scan_start = job_acc && job.is_last;
            ST_DECIDE: scan_start = !found_reg;
            ST_CT:
            begin
                alu_op = ALU_ADD;
                alu_a  = time_reg;
                alu_b  = TIME_W'(best_bur_reg);
            end
            ST_TAT:
            begin
                alu_op = ALU_SUB;
                alu_a  = ct_reg;
                alu_b  = TIME_W'(best_arr_reg);
            end
            ST_WT:
            begin
                alu_op     = ALU_SUB;
                alu_a      = tat_reg;
                alu_b      = TIME_W'(best_bur_reg);
                scan_start = out_free && !run_done;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            loaded_reg   <= '0;
            scan_reg     <= '0;
            served_reg   <= '0;
            done_reg     <= '0;
            time_reg     <= '0;
            eval_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            eval_vld_reg <= (state_reg == ST_SCAN);

            if (scan_start)
            begin
                scan_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                scan_reg <= scan_reg + cnt_t'(1);
            end

            if (scan_start)
            begin
                found_reg <= 1'b0;
            end
            else if (eval_vld_reg && eval_take)
            begin
                found_reg <= 1'b1;
            end

            if (state_reg == ST_DECIDE && !found_reg)
            begin
                time_reg <= TIME_W'(early_reg);   // nothing arrived: jump ahead
            end
            else if (state_reg == ST_CT)
            begin
                time_reg <= alu_y;
            end
            else if (commit && run_done)
            begin
                time_reg <= '0;
            end

            if (state_reg == ST_LOAD && job_acc && !full)
            begin
                loaded_reg <= loaded_reg + cnt_t'(1);
            end
            else if (commit && run_done)
            begin
                loaded_reg <= '0;
            end

            if (commit)
            begin
                if (run_done)
                begin
                    done_reg   <= '0;
                    served_reg <= '0;
                end
                else
                begin
                    done_reg[best_idx_reg] <= 1'b1;
                    served_reg             <= served_reg + cnt_t'(1);
                end
            end

            if (commit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        eval_idx_reg <= scan_reg[IDX_W-1:0];

        if (scan_start)
        begin
            early_reg <= '1;
        end
        else if (eval_vld_reg && eval_pend && (rd_entry.arrival < early_reg))
        begin
            early_reg <= rd_entry.arrival;
        end

        if (!scan_start && eval_vld_reg && eval_take)
        begin
            best_idx_reg <= eval_idx_reg;
            best_arr_reg <= rd_entry.arrival;
            best_bur_reg <= rd_entry.burst;
        end

        if (state_reg == ST_CT)
        begin
            ct_reg <= alu_y;
        end
        if (state_reg == ST_TAT)
        begin
            tat_reg <= alu_y;
        end

        if (commit)
        begin
            out_idx_reg  <= OUT_IDX_W'(best_idx_reg);
            out_arr_reg  <= best_arr_reg;
            out_bur_reg  <= best_bur_reg;
            out_ct_reg   <= ct_reg;
            out_tat_reg  <= tat_reg;
            out_wt_reg   <= alu_y;
            out_last_reg <= run_done;
        end
    end

    assign result.valid           = out_vld_reg;
    assign result.served_index    = out_idx_reg;
    assign result.served_arrival  = out_arr_reg;
    assign result.served_burst    = out_bur_reg;
    assign result.completion_time = out_ct_reg;
    assign result.turnaround_time = out_tat_reg;
    assign result.waiting_time    = out_wt_reg;
    assign result.final_entry     = out_last_reg;

endmodule

// ----- hdl/sjf_nonpreemptive_scheduler_top.sv -----
// Block-level wrapper of the shortest-job-first scheduler.
//
// Load processes on job, one beat each, with is_last on the final one; the
// schedule then runs and returns one result beat per process on result, in
// service order, with final_entry on the last. job.ready drops during a run.
// The time to serve each process is set by the scan of the n processes
// loaded, through the single read port of the process store; a time jump
// to the next arrival adds another scan.
module sjf_nonpreemptive_scheduler_top
    import sjfs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sjfs_job_if.sink      job,
    sjfs_result_if.source result
);

    sjfs_top u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .job    (job),
        .result (result)
    );

endmodule

// ----- hdl/sjfs_checker.sv -----
// Port-level checks for the scheduler, bound to the top level.
module sjfs_checker
    import sjfs_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  job_valid,
    input logic  job_ready,
    input logic  job_is_last,
    input logic  res_valid,
    input logic  res_ready,
    input data_t res_arrival,
    input data_t res_burst,
    input time_t res_ct,
    input time_t res_tat,
    input time_t res_wt
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_ct))
        else $error("result beat dropped or changed while stalled");

    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && job_ready && job_is_last |=> !job_ready)
        else $error("job accepted right after last beat");

    a_tat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_tat == res_ct - TIME_W'(res_arrival))
        else $error("turnaround mismatch");

    a_wt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_wt == res_tat - TIME_W'(res_burst))
        else $error("waiting time mismatch");

endmodule

bind sjf_nonpreemptive_scheduler_top sjfs_checker u_sjfs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (job.valid),
    .job_ready   (job.ready),
    .job_is_last (job.is_last),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_arrival (result.served_arrival),
    .res_burst   (result.served_burst),
    .res_ct      (result.completion_time),
    .res_tat     (result.turnaround_time),
    .res_wt      (result.waiting_time)
);
